FILE: design/fmtx_pkg.sv
// shared types and constants for the fm transmitter setting frame builder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fmtx_pkg;

  // setting commands
  typedef enum logic [2:0] {
    CMD_FREQ     = 3'd0,
    CMD_POWER    = 3'd1,
    CMD_GAIN     = 3'd2,
    CMD_STEREO   = 3'd3,
    CMD_BYPASS   = 3'd4,
    CMD_PWR_MGMT = 3'd5
  } cmd_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FREQ_ADDR  = 3'd0;
  localparam logic [2:0] CFG_MODE_ADDR  = 3'd1;
  localparam logic [2:0] CFG_POWER_ADDR = 3'd2;
  localparam logic [2:0] CFG_POWER_MASK = 3'd3;
  localparam logic [2:0] CFG_MONO_MASK  = 3'd4;
  localparam logic [2:0] CFG_GAIN_MASK  = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ADDR_W      = 7;
  localparam int VALUE_W     = 16;

  // device id byte that opens every frame
  localparam logic [7:0] DEVICE_ID = 8'h1D;

  // value * 2^20 / 19 = value * 55188 + floor(4 * value / 19)
  // the small quotient is (x * 55189) >> 20, exact for x below 2^14
  localparam logic [15:0] FREQ_MUL_HI = 16'd55188;
  localparam logic [15:0] FREQ_MUL_LO = 16'd55189;
  localparam int FREQ_VAL_W  = 12;
  localparam int FREQ_HI_W   = 28;
  localparam int FREQ_X_W    = 14;
  localparam int FREQ_LO_W   = 30;
  localparam int FREQ_SHIFT  = 20;
  localparam int FREQ_CORR_W = 10;

  localparam int QUEUE_DEPTH_DEF = 2;

  // one queued frame: frequency frames carry four data bytes, others two
  typedef struct packed {
    logic              is_freq;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } frame_entry_t;

endpackage

FILE: design/fm_tx_setting_frame_builder.sv
// top level of the fm transmitter setting frame builder
// instantiates fmtx_front, fmtx_queue and fmtx_back; depends on fmtx_pkg
`timescale 1ns / 1ps

// Turns setting commands into two-wire register-write byte frames.
// Input channel: in_command and in_setting_value, one beat per command,
// taken when in_valid is high and in_stall is low. Output channel: one
// beat per bus byte on out_bus_byte, with out_frame_start on the device id
// byte and out_frame_end on the last byte of the frame.
// A frequency command gives six bytes, power, gain and stereo give four,
// bypass, power management and unused codes give none.
// The first byte of a frame passes stage one, the frame queue and the
// output register after its command is accepted. The byte sequencer sends
// one byte per cycle while out_stall is low; commands are accepted back to
// back while the frame queue has room.
// Configuration: cfg_wr_en, cfg_index and cfg_wdata write one register per
// cycle; writes are meant for idle periods only.
// Reset (rst_n low, synchronous) clears the queue, the mode shadow and the
// sequencer and loads the register defaults. When out_stall is high the
// current byte holds; the queue fills and then in_stall rises.
module fm_tx_setting_frame_builder
  import fmtx_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_command,
  input  logic [VALUE_W-1:0]     in_setting_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_bus_byte,
  output logic                   out_frame_start,
  output logic                   out_frame_end
);

  logic         q_push, q_full, q_pop, q_not_empty;
  frame_entry_t q_wdata, q_rdata;

  // command intake and frame preparation
  fmtx_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_setting_value (in_setting_value),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_full           (q_full)
  );

  // frame queue
  fmtx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  // byte sequencer and output register
  fmtx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_not_empty     (q_not_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bus_byte    (out_bus_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end)
  );

endmodule

FILE: design/fmtx_front.sv
// front end: configuration registers, mode shadow, command decode and
// frequency quotient pipeline; depends on fmtx_pkg
`timescale 1ns / 1ps

module fmtx_front
  import fmtx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_command,
  input  logic [VALUE_W-1:0]     in_setting_value,
  output logic                   q_push,
  output frame_entry_t           q_wdata,
  input  logic                   q_full
);

  logic [ADDR_W-1:0]  freq_addr_r, mode_addr_r, power_addr_r;
  logic [VALUE_W-1:0] power_mask_r, mono_mask_r, gain_mask_r;
  logic [VALUE_W-1:0] shadow_r, shadow_nxt;

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_is_freq_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [VALUE_W-1:0]     s1_word_r;
  logic [FREQ_HI_W-1:0]   s1_hi_r;
  logic [FREQ_CORR_W-1:0] s1_corr_r;

  logic                   accept;
  logic                   can_move;
  logic                   emits;
  logic [ADDR_W-1:0]      addr_sel;
  logic [VALUE_W-1:0]     word_sel;
  logic [VALUE_W-1:0]     field_mask;
  logic [FREQ_VAL_W-1:0]  freq_val;
  logic [FREQ_X_W-1:0]    freq_x;
  logic [FREQ_HI_W-1:0]   prod_hi;
  logic [FREQ_LO_W-1:0]   prod_lo;

  // stage one moves on whenever it is empty or the queue has room
  assign can_move = !s1_valid_r || !q_full;
  assign in_stall = !can_move;
  assign accept   = in_valid && can_move;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_addr_r  <= '0;
      mode_addr_r  <= ADDR_W'(2);
      power_addr_r <= ADDR_W'(3);
      power_mask_r <= '1;
      mono_mask_r  <= VALUE_W'(1);
      gain_mask_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FREQ_ADDR:  freq_addr_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_MODE_ADDR:  mode_addr_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_POWER_ADDR: power_addr_r <= cfg_wdata[ADDR_W-1:0];
        CFG_POWER_MASK: power_mask_r <= cfg_wdata;
        CFG_MONO_MASK:  mono_mask_r  <= cfg_wdata;
        CFG_GAIN_MASK:  gain_mask_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // command decode and shadow update
  always_comb begin
    emits      = 1'b0;
    addr_sel   = freq_addr_r;
    word_sel   = '0;
    shadow_nxt = shadow_r;
    field_mask = (in_command == CMD_GAIN) ? gain_mask_r : mono_mask_r;
    case (in_command)
      CMD_FREQ: begin
        emits    = 1'b1;
        addr_sel = freq_addr_r;
      end
      CMD_POWER: begin
        emits    = 1'b1;
        addr_sel = power_addr_r;
        word_sel = in_setting_value & power_mask_r;
      end
      CMD_GAIN, CMD_STEREO: begin
        emits      = 1'b1;
        addr_sel   = mode_addr_r;
        shadow_nxt = (shadow_r & ~field_mask) | (in_setting_value & field_mask);
        word_sel   = shadow_nxt;
      end
      default: ;
    endcase
  end

  // frequency products, only the low 12 bits survive the 2^20 scaling
  assign freq_val = in_setting_value[FREQ_VAL_W-1:0];
  assign freq_x   = {freq_val, 2'b00};
  assign prod_hi  = FREQ_HI_W'(freq_val * FREQ_MUL_HI);
  assign prod_lo  = FREQ_LO_W'(freq_x * FREQ_MUL_LO);

  assign s1_valid_nxt = can_move ? (accept && emits) : s1_valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      shadow_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        shadow_r <= shadow_nxt;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_freq_r <= (in_command == CMD_FREQ);
      s1_addr_r    <= addr_sel;
      s1_word_r    <= word_sel;
      s1_hi_r      <= prod_hi;
      s1_corr_r    <= prod_lo[FREQ_LO_W-1:FREQ_SHIFT];
    end
  end

  // stage two: finish the quotient and hand the frame to the queue
  assign q_push          = s1_valid_r && !q_full;
  assign q_wdata.is_freq = s1_is_freq_r;
  assign q_wdata.addr    = s1_addr_r;
  assign q_wdata.data    = s1_is_freq_r ? (32'(s1_hi_r) + 32'(s1_corr_r))
                                        : {16'h0000, s1_word_r};

`ifndef SYNTHESIS
  // commands without a frame never occupy stage one
  a_no_frame_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !emits) |=> !s1_valid_r)
    else $error("silent command loaded stage one");
  // the shadow moves only with an accepted beat
  a_shadow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !accept) |=> $stable(shadow_r))
    else $error("mode shadow changed without a beat");
`endif

endmodule

FILE: design/fmtx_queue.sv
// short frame queue between front end and byte sequencer
// depends on fmtx_pkg for the entry type
`timescale 1ns / 1ps

module fmtx_queue
  import fmtx_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  frame_entry_t wdata,
  output logic         full,
  input  logic         pop,
  output frame_entry_t rdata,
  output logic         not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: design/fmtx_back.sv
// byte sequencer: walks the head frame one byte per beat into the
// output register; depends on fmtx_pkg
`timescale 1ns / 1ps

module fmtx_back
  import fmtx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  frame_entry_t q_rdata,
  input  logic         q_not_empty,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_bus_byte,
  output logic         out_frame_start,
  output logic         out_frame_end
);

  localparam logic [2:0] POS_ID      = 3'd0;
  localparam logic [2:0] POS_ADDR    = 3'd1;
  localparam logic [2:0] POS_D0      = 3'd2;
  localparam logic [2:0] POS_D1      = 3'd3;
  localparam logic [2:0] POS_D2      = 3'd4;
  localparam logic [2:0] POS_D3      = 3'd5;
  localparam logic [2:0] POS_LAST_WD = POS_D1;
  localparam logic [2:0] POS_LAST_FQ = POS_D3;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_start_r, out_end_r;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;

  // load a byte when the output register is empty or being drained
  assign load  = q_not_empty && (!out_valid_r || !out_stall);
  assign last  = (idx_r == (q_rdata.is_freq ? POS_LAST_FQ : POS_LAST_WD));
  assign q_pop = load && last;
  assign idx_nxt = last ? POS_ID : idx_r + 3'd1;

  // byte select by position in the frame
  always_comb begin
    case (idx_r)
      POS_ID:   byte_sel = DEVICE_ID;
      POS_ADDR: byte_sel = {q_rdata.addr, 1'b0};
      POS_D0:   byte_sel = q_rdata.data[15:8];
      POS_D1:   byte_sel = q_rdata.data[7:0];
      POS_D2:   byte_sel = q_rdata.data[31:24];
      POS_D3:   byte_sel = q_rdata.data[23:16];
      default:  byte_sel = 8'h00;
    endcase
  end

  // position counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= POS_ID;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= byte_sel;
      out_start_r <= (idx_r == POS_ID);
      out_end_r   <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bus_byte    = out_byte_r;
  assign out_frame_start = out_start_r;
  assign out_frame_end   = out_end_r;

`ifndef SYNTHESIS
  // the sequencer never runs past the end of a frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (idx_r <= (q_rdata.is_freq ? POS_LAST_FQ : POS_LAST_WD)))
    else $error("byte position beyond frame end");
`endif

endmodule
